// ===== rtl/uer_pkg.sv =====
// Shared types, codes and constants of the ultrasonic echo ranger.
`timescale 1ns / 1ps
`default_nettype none
package uer_pkg;

    localparam int unsigned TRIG_W  = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned SINCE_W = 17;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned DIST_W  = 24;
    localparam int unsigned PROD_W  = TICK_W + SCALE_W;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 24;

    localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_HIGH = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_FRESH    = 3'd0,
        ST_CACHED   = 3'd1,
        ST_NO_ECHO  = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NONE     = 3'd5
    } t_status;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TRIG_WIDTH = 3'd0,
        CFG_TIMEOUT    = 3'd1,
        CFG_MIN_INTVL  = 3'd2,
        CFG_SCALE      = 3'd3,
        CFG_MIN_DIST   = 3'd4,
        CFG_MAX_DIST   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [TRIG_W-1:0]  trig_width;
        logic [TICK_W-1:0]  timeout;
        logic [SINCE_W-1:0] min_intvl;
        logic [SCALE_W-1:0] scale;
        logic [DIST_W-1:0]  min_dist;
        logic [DIST_W-1:0]  max_dist;
    } t_cfg;

    typedef struct packed {
        logic              trigger_level;
        logic              result_valid;
        t_status           status;
        logic [DIST_W-1:0] distance_q8;
        logic              ready_res;
        logic [DIST_W-1:0] last_distance_q8;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/uer_ifs.sv =====
// Channel interfaces: tick input, result output and register write.
`timescale 1ns / 1ps
`default_nettype none
interface uer_in_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic start_request;
    modport source (output valid, output echo_level, output start_request, input ready);
    modport sink (input valid, input echo_level, input start_request, output ready);
endinterface

interface uer_res_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger_level;
    logic                       result_valid;
    logic [2:0]                 status;
    logic [uer_pkg::DIST_W-1:0] distance_q8;
    logic                       ready_res;
    logic [uer_pkg::DIST_W-1:0] last_distance_q8;
    modport source (output valid, output trigger_level, output result_valid, output status,
                    output distance_q8, output ready_res, output last_distance_q8,
                    input ready);
    modport sink (input valid, input trigger_level, input result_valid, input status,
                  input distance_q8, input ready_res, input last_distance_q8,
                  output ready);
endinterface

interface uer_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [uer_pkg::CIDX_W-1:0] index;
    logic [uer_pkg::CDAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
// Top level of the ultrasonic echo ranger.
`timescale 1ns / 1ps
`default_nettype none
// Ultrasonic echo ranger core.
// i_in carries one request per microsecond tick: the sampled echo level and
// a measurement request flag. o_res returns exactly one request per input
// request, in order, with the trigger drive for that tick, a finish flag,
// status, distance (cm, Q8), interval-ready flag and cached distance.
// i_cfg writes the six registers (index 0..5, others ignored); it is always
// ready and must only be used while the block is idle.
// Datapath: input register -> state update and result logic -> result
// register; a tick passes both registers. Throughput is one tick per cycle
// unless the receiver stalls; the echo width is scaled by a running sum
// (scale added once per high tick), so no multiplier sits in the path.
// Reset (synchronous, active low) returns the registers to their defaults,
// the sequencer to idle, empties the cache and saturates the interval timer.
// When the receiver stalls, the result register holds, the input register
// fills, and i_in.ready drops; nothing is lost or repeated.
module ultrasonic_echo_ranger_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uer_in_if.sink     i_in,
    uer_res_if.source  o_res,
    uer_cfg_if.sink    i_cfg
);

    logic          r_in_vld;
    logic          r_echo;
    logic          r_req;
    logic          r_out_vld;
    uer_pkg::t_res r_res;
    uer_pkg::t_res w_res;
    uer_pkg::t_cfg w_cfg;
    logic          w_adv;

    // Tick in the input register moves on when the result slot is free
    assign w_adv       = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready  = !r_in_vld || w_adv;
    assign i_cfg.ready = 1'b1;

    uer_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_cfg     (w_cfg)
    );

    uer_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_echo  (r_echo),
        .i_req   (r_req),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_echo <= i_in.echo_level;
            r_req  <= i_in.start_request;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.trigger_level    = r_res.trigger_level;
    assign o_res.result_valid     = r_res.result_valid;
    assign o_res.status           = 3'(r_res.status);
    assign o_res.distance_q8      = r_res.distance_q8;
    assign o_res.ready_res        = r_res.ready_res;
    assign o_res.last_distance_q8 = r_res.last_distance_q8;

`ifndef SYNTHESIS
    a_fail_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_res.status != uer_pkg::ST_FRESH)
        && (r_res.status != uer_pkg::ST_CACHED) |-> (r_res.distance_q8 == '0))
        else $error("failed request carries a distance");
    a_fresh_cached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.result_valid && (r_res.status == uer_pkg::ST_FRESH)
        |-> (r_res.last_distance_q8 == r_res.distance_q8))
        else $error("fresh distance not cached");
    a_idle_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_res.result_valid
        |-> (r_res.status == uer_pkg::ST_FRESH) && (r_res.distance_q8 == '0))
        else $error("status set on a non-finishing tick");
`endif

endmodule
`default_nettype wire

// ===== rtl/uer_cfg_regs.sv =====
// Configuration register bank.
`timescale 1ns / 1ps
`default_nettype none
module uer_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [uer_pkg::CIDX_W-1:0] i_wr_idx,
    input  logic [uer_pkg::CDAT_W-1:0] i_wr_data,
    output uer_pkg::t_cfg              o_cfg
);

    uer_pkg::t_cfg r_cfg;
    uer_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (uer_pkg::t_cfg_idx'(i_wr_idx))
                uer_pkg::CFG_TRIG_WIDTH: n_cfg.trig_width = i_wr_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::CFG_TIMEOUT:    n_cfg.timeout    = i_wr_data[uer_pkg::TICK_W-1:0];
                uer_pkg::CFG_MIN_INTVL:  n_cfg.min_intvl  = i_wr_data[uer_pkg::SINCE_W-1:0];
                uer_pkg::CFG_SCALE:      n_cfg.scale      = i_wr_data[uer_pkg::SCALE_W-1:0];
                uer_pkg::CFG_MIN_DIST:   n_cfg.min_dist   = i_wr_data[uer_pkg::DIST_W-1:0];
                uer_pkg::CFG_MAX_DIST:   n_cfg.max_dist   = i_wr_data[uer_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_width <= 8'd10;
            r_cfg.timeout    <= 16'd30000;
            r_cfg.min_intvl  <= 17'd60000;
            r_cfg.scale      <= 16'd1124;
            r_cfg.min_dist   <= 24'd512;
            r_cfg.max_dist   <= 24'd102400;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/uer_step.sv =====
// Per-tick ranging state machine: trigger, echo waits, width timing, cache.
`timescale 1ns / 1ps
`default_nettype none
module uer_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_echo,
    input  logic          i_req,
    input  uer_pkg::t_cfg i_cfg,
    output uer_pkg::t_res o_res
);

    uer_pkg::t_phase               r_phase, n_phase;
    logic [uer_pkg::TICK_W-1:0]    r_ticks, n_ticks;
    logic [uer_pkg::PROD_W-1:0]    r_prod,  n_prod;   // ticks * scale, kept as running sum
    logic [uer_pkg::SINCE_W-1:0]   r_since, n_since;
    logic [uer_pkg::DIST_W-1:0]    r_cache, n_cache;
    logic                          r_cache_vld, n_cache_vld;

    logic [uer_pkg::SINCE_W-1:0]   w_since_inc;
    logic [uer_pkg::TRIG_W-1:0]    w_tw;
    logic [uer_pkg::TICK_W-1:0]    w_ticks_inc;
    logic [uer_pkg::DIST_W-1:0]    w_dist;

    assign w_since_inc = (r_since != uer_pkg::SINCE_MAX) ? r_since + 1'b1 : r_since;
    assign w_tw        = (i_cfg.trig_width == '0) ? uer_pkg::TRIG_W'(1) : i_cfg.trig_width;
    assign w_ticks_inc = r_ticks + 1'b1;
    assign w_dist      = r_prod[uer_pkg::PROD_W-1 -: uer_pkg::DIST_W];

    always_comb begin
        n_phase     = r_phase;
        n_ticks     = r_ticks;
        n_prod      = r_prod;
        n_since     = w_since_inc;
        n_cache     = r_cache;
        n_cache_vld = r_cache_vld;
        o_res       = '0;
        o_res.status = uer_pkg::ST_FRESH;

        unique case (r_phase)
            uer_pkg::PH_IDLE: begin
                if (i_req) begin
                    if (w_since_inc < i_cfg.min_intvl) begin
                        o_res.result_valid = 1'b1;
                        if (r_cache_vld) begin
                            o_res.status      = uer_pkg::ST_CACHED;
                            o_res.distance_q8 = r_cache;
                        end else begin
                            o_res.status = uer_pkg::ST_NONE;
                        end
                    end else begin
                        o_res.trigger_level = 1'b1;
                        if (w_tw == uer_pkg::TRIG_W'(1)) begin
                            n_phase = uer_pkg::PH_RISE;
                            n_ticks = '0;
                        end else begin
                            n_phase = uer_pkg::PH_TRIG;
                            n_ticks = uer_pkg::TICK_W'(1);
                        end
                    end
                end
            end
            uer_pkg::PH_TRIG: begin
                o_res.trigger_level = 1'b1;
                n_ticks = w_ticks_inc;
                if (w_ticks_inc >= {{(uer_pkg::TICK_W-uer_pkg::TRIG_W){1'b0}}, w_tw}) begin
                    n_phase = uer_pkg::PH_RISE;
                    n_ticks = '0;
                end
            end
            uer_pkg::PH_RISE: begin
                if (i_echo) begin
                    n_phase = uer_pkg::PH_HIGH;
                    n_ticks = uer_pkg::TICK_W'(1);
                    n_prod  = {{uer_pkg::TICK_W{1'b0}}, i_cfg.scale};
                end else if (r_ticks >= i_cfg.timeout) begin
                    o_res.result_valid = 1'b1;
                    o_res.status       = uer_pkg::ST_NO_ECHO;
                    n_phase            = uer_pkg::PH_IDLE;
                    n_ticks            = '0;
                end else begin
                    n_ticks = w_ticks_inc;
                end
            end
            uer_pkg::PH_HIGH: begin
                if (i_echo) begin
                    if (r_ticks >= i_cfg.timeout) begin
                        o_res.result_valid = 1'b1;
                        o_res.status       = uer_pkg::ST_TOO_LONG;
                        n_phase            = uer_pkg::PH_IDLE;
                        n_ticks            = '0;
                    end else begin
                        n_ticks = w_ticks_inc;
                        n_prod  = r_prod + {{uer_pkg::TICK_W{1'b0}}, i_cfg.scale};
                    end
                end else begin
                    o_res.result_valid = 1'b1;
                    if (w_dist < i_cfg.min_dist || w_dist > i_cfg.max_dist) begin
                        o_res.status = uer_pkg::ST_RANGE;
                    end else begin
                        o_res.status      = uer_pkg::ST_FRESH;
                        o_res.distance_q8 = w_dist;
                        n_cache           = w_dist;
                        n_cache_vld       = 1'b1;
                        n_since           = '0;
                    end
                    n_phase = uer_pkg::PH_IDLE;
                    n_ticks = '0;
                end
            end
            default: ;
        endcase

        o_res.ready_res        = (n_since >= i_cfg.min_intvl);
        o_res.last_distance_q8 = n_cache_vld ? n_cache : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= uer_pkg::PH_IDLE;
            r_ticks     <= '0;
            r_since     <= uer_pkg::SINCE_MAX;
            r_cache     <= '0;
            r_cache_vld <= 1'b0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_since     <= n_since;
            r_cache     <= n_cache;
            r_cache_vld <= n_cache_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
        end
    end

`ifndef SYNTHESIS
    a_idle_ticks_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == uer_pkg::PH_IDLE) |-> (r_ticks == '0))
        else $error("phase counter not cleared in idle");
    a_trig_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_res.trigger_level |-> !o_res.result_valid)
        else $error("trigger driven on a finishing tick");
    a_success_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_res.result_valid && (o_res.status == uer_pkg::ST_FRESH)
        |=> (r_since == '0) && r_cache_vld)
        else $error("success did not restart interval");
`endif

endmodule
`default_nettype wire

// ===== tb/ultrasonic_echo_ranger_checker.sv =====
// Scoreboard for the echo ranger: tracks register writes, predicts every tick result, compares.
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_checker
    import uer_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    uer_in_if    in_ch,
    uer_res_if   res_ch,
    uer_cfg_if   cfg_ch,
    output int   o_failures,
    output int   o_pending
);

    localparam logic [TRIG_W-1:0]  RST_TRIG_WIDTH = 8'd10;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT    = 16'd30000;
    localparam logic [SINCE_W-1:0] RST_MIN_INTVL  = 17'd60000;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 16'd1124;
    localparam logic [DIST_W-1:0]  RST_MIN_DIST   = 24'd512;
    localparam logic [DIST_W-1:0]  RST_MAX_DIST   = 24'd102400;

    // Shadow of the register file and of the sequencer.
    t_cfg               regs;
    t_phase             ph;
    logic [TICK_W-1:0]  ph_ticks;
    logic [SINCE_W-1:0] since_ok;
    logic [DIST_W-1:0]  cache_dist;
    logic               cache_ok;

    t_res tick_results_q[$];
    int   failures;

    // One microsecond tick of the ranger.
    task automatic advance_ranger(input logic echo, input logic req, output t_res r);
        logic [TRIG_W-1:0] tw;
        logic [PROD_W-1:0] prod;
        logic [DIST_W-1:0] meas_q8;
        r = '0;
        r.status = ST_FRESH;
        tw = (regs.trig_width == '0) ? TRIG_W'(1) : regs.trig_width;
        if (since_ok != SINCE_MAX) since_ok = since_ok + 1'b1;
        case (ph)
            PH_IDLE: begin
                if (req) begin
                    if (since_ok < regs.min_intvl) begin
                        r.result_valid = 1'b1;
                        if (cache_ok) begin
                            r.status      = ST_CACHED;
                            r.distance_q8 = cache_dist;
                        end else begin
                            r.status = ST_NONE;
                        end
                    end else begin
                        r.trigger_level = 1'b1;
                        if (tw <= TRIG_W'(1)) begin
                            ph       = PH_RISE;
                            ph_ticks = '0;
                        end else begin
                            ph       = PH_TRIG;
                            ph_ticks = TICK_W'(1);
                        end
                    end
                end
            end
            PH_TRIG: begin
                r.trigger_level = 1'b1;
                ph_ticks = ph_ticks + 1'b1;
                if (ph_ticks >= TICK_W'(tw)) begin
                    ph       = PH_RISE;
                    ph_ticks = '0;
                end
            end
            PH_RISE: begin
                if (echo) begin
                    ph       = PH_HIGH;
                    ph_ticks = TICK_W'(1);
                end else if (ph_ticks >= regs.timeout) begin
                    r.result_valid = 1'b1;
                    r.status       = ST_NO_ECHO;
                    ph             = PH_IDLE;
                    ph_ticks       = '0;
                end else begin
                    ph_ticks = ph_ticks + 1'b1;
                end
            end
            default: begin
                if (echo) begin
                    if (ph_ticks >= regs.timeout) begin
                        r.result_valid = 1'b1;
                        r.status       = ST_TOO_LONG;
                        ph             = PH_IDLE;
                        ph_ticks       = '0;
                    end else begin
                        ph_ticks = ph_ticks + 1'b1;
                    end
                end else begin
                    // width * Q16 scale, Q8 kept
                    prod = PROD_W'(ph_ticks) * PROD_W'(regs.scale);
                    meas_q8 = prod[PROD_W-1:8];
                    r.result_valid = 1'b1;
                    if (meas_q8 < regs.min_dist || meas_q8 > regs.max_dist) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.status      = ST_FRESH;
                        r.distance_q8 = meas_q8;
                        cache_dist    = meas_q8;
                        cache_ok      = 1'b1;
                        since_ok      = '0;
                    end
                    ph       = PH_IDLE;
                    ph_ticks = '0;
                end
            end
        endcase
        r.ready_res        = (since_ok >= regs.min_intvl);
        r.last_distance_q8 = cache_ok ? cache_dist : '0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        t_res fresh;
        if (!i_rst_n) begin
            regs.trig_width = RST_TRIG_WIDTH;
            regs.timeout    = RST_TIMEOUT;
            regs.min_intvl  = RST_MIN_INTVL;
            regs.scale      = RST_SCALE;
            regs.min_dist   = RST_MIN_DIST;
            regs.max_dist   = RST_MAX_DIST;
            ph         = PH_IDLE;
            ph_ticks   = '0;
            since_ok   = SINCE_MAX;
            cache_dist = '0;
            cache_ok   = 1'b0;
            failures   = 0;
            tick_results_q.delete();
        end else begin
            // pop before push: a result always belongs to an older request
            if (res_ch.valid && res_ch.ready) begin
                if (tick_results_q.size() == 0) begin
                    failures++;
                    $display("%0t: result with nothing expected, expected none actual %0h",
                             $time, {res_ch.trigger_level, res_ch.result_valid,
                                     res_ch.status, res_ch.distance_q8});
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("trigger_level", 32'(want.trigger_level), 32'(res_ch.trigger_level));
                    check_field("result_valid", 32'(want.result_valid), 32'(res_ch.result_valid));
                    check_field("status", 32'(want.status), 32'(res_ch.status));
                    check_field("distance_q8", 32'(want.distance_q8), 32'(res_ch.distance_q8));
                    check_field("ready_res", 32'(want.ready_res), 32'(res_ch.ready_res));
                    check_field("last_distance_q8", 32'(want.last_distance_q8),
                                32'(res_ch.last_distance_q8));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_TRIG_WIDTH: regs.trig_width = cfg_ch.data[TRIG_W-1:0];
                    CFG_TIMEOUT:    regs.timeout    = cfg_ch.data[TICK_W-1:0];
                    CFG_MIN_INTVL:  regs.min_intvl  = cfg_ch.data[SINCE_W-1:0];
                    CFG_SCALE:      regs.scale      = cfg_ch.data[SCALE_W-1:0];
                    CFG_MIN_DIST:   regs.min_dist   = cfg_ch.data[DIST_W-1:0];
                    CFG_MAX_DIST:   regs.max_dist   = cfg_ch.data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                advance_ranger(in_ch.echo_level, in_ch.start_request, fresh);
                tick_results_q.push_back(fresh);
            end
        end
        o_failures <= failures;
        o_pending  <= tick_results_q.size();
    end

endmodule

// ===== tb/ultrasonic_echo_ranger_core_tb.sv =====
// Testbench top for the echo ranger core: clock, reset, tick stimulus, result sink, verdict.
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_core_tb;
    import uer_pkg::*;

    // Register indexes the block decodes to nothing.
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_TICKS   = 90;    // random ticks per phase, tail excluded
    localparam int SETTLE_CYCLES = 8;     // well over the core latency
    localparam int HOLD_AT       = 600;   // result count at which the sink holds off
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;  // cycles without any request moving

    logic i_clk;
    logic i_rst_n;

    uer_in_if  in_ch ();
    uer_res_if res_ch ();
    uer_cfg_if cfg_ch ();

    int chk_failures;
    int chk_pending;

    // Effective trigger width and echo timeout of the current setting,
    // used only to shape the echo waveforms.
    int cur_tw;
    int cur_to;
    bit no_idle;
    int idle_cycles;

    ultrasonic_echo_ranger_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    ultrasonic_echo_ranger_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .res_ch     (res_ch),
        .cfg_ch     (cfg_ch),
        .o_failures (chk_failures),
        .o_pending  (chk_pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog: a run that stops moving requests is a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
                     (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One tick request. Valid is only dropped when a gap is drawn, so
    // back-to-back requests never see a low-then-high in the same step.
    task automatic send_tick(input logic echo, input logic req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.echo_level    <= echo;
        in_ch.start_request <= req;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Stop sending, wait for every outstanding result, then a few more cycles.
    task automatic drain;
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Raw 24-bit data goes on the bus; the block keeps the low bits of each register.
    task automatic program_regs(input logic [CDAT_W-1:0] tw, input logic [CDAT_W-1:0] tmo,
                                input logic [CDAT_W-1:0] intvl, input logic [CDAT_W-1:0] scale,
                                input logic [CDAT_W-1:0] lo, input logic [CDAT_W-1:0] hi);
        drain();
        write_reg(CFG_TRIG_WIDTH, tw);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MIN_INTVL, intvl);
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_MIN_DIST, lo);
        write_reg(CFG_MAX_DIST, hi);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CDAT_W'($urandom));
        cfg_ch.valid <= 1'b0;
        cur_tw = (tw[TRIG_W-1:0] == '0) ? 1 : int'(tw[TRIG_W-1:0]);
        cur_to = int'(tmo[TICK_W-1:0]);
    endtask

    // A whole measurement: request, trigger ticks (echo there is ignored),
    // low ticks before the rise, high ticks of the echo, then one low tick.
    // busy_req sprinkles requests that should be ignored while running.
    task automatic measure(input int rise_wait, input int width, input logic busy_req);
        send_tick($urandom_range(0, 1), 1'b1);
        repeat (cur_tw - 1) send_tick($urandom_range(0, 1), busy_req & $urandom_range(0, 1));
        repeat (rise_wait) send_tick(1'b0, busy_req & $urandom_range(0, 1));
        repeat (width) send_tick(1'b1, busy_req & $urandom_range(0, 1));
        send_tick(1'b0, 1'b0);
    endtask

    // Result sink: random stall per request, and one long hold-off so that
    // the block fills up and backs off its input.
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        int unsigned sc;
        int unsigned lo;
        int unsigned hi;
        int unsigned swap;
        int unsigned intvl;
        int unsigned kind;
        int          phase_end;
        int          sent;
        logic [CDAT_W-1:0] tw_raw;
        logic [CDAT_W-1:0] tmo_raw;

        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.echo_level    <= 1'b0;
        in_ch.start_request <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_TRIG_WIDTH;
        cfg_ch.data         <= '0;
        no_idle = 1'b0;
        cur_tw  = 10;
        cur_to  = 30000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: two short echoes, both below the minimum distance.
        // No success yet, so the interval timer stays saturated.
        measure(2, 3, 1'b1);
        measure(0, 40, 1'b0);

        // Longest timeout and interval (high data bits masked off), unit
        // trigger, zero scale: a zero-distance success, then cached replies.
        program_regs(24'hFFFF01, 24'hFFFFFF, 24'hFFFFFF, 24'hFF0000, 24'h000000, 24'h000000);
        measure(3, 4, 1'b0);
        send_tick(1'b0, 1'b1);
        measure(0, 2, 1'b0);

        // Zero trigger width and zero timeout, no interval, top scale.
        program_regs(24'h000000, 24'h000000, 24'h000000, 24'h00FFFF, 24'h000000, 24'hFFFFFF);
        measure(1, 0, 1'b0);    // first low while waiting: no echo
        measure(0, 2, 1'b0);    // second high sample: echo too long
        measure(0, 1, 1'b0);    // single-tick echo: success
        send_tick(1'b0, 1'b1);  // interval of zero: measures again
        send_tick(1'b0, 1'b0);

        // Widest trigger with requests during it; minimum above maximum.
        program_regs(24'h0000FF, 24'h000005, 24'h000014, 24'h00FFFF, 24'hFFFFFF, 24'h000000);
        repeat (25) send_tick(1'b0, 1'b0);
        measure(2, 4, 1'b1);

        // Random phases: mostly whole measurements with random timing
        // around the timeout boundaries, some noise and some lost echoes.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            tw_raw  = {16'($urandom), (p == 5) ? 8'd12 : 8'($urandom_range(0, 6))};
            tmo_raw = {8'($urandom), 16'($urandom_range(0, 40))};
            case (p % 4)
                0:       intvl = 0;
                3:       intvl = $urandom_range(0, 131071);
                default: intvl = $urandom_range(1, 80);
            endcase
            if (p == 7) intvl = 131071;
            sc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(128, 2048);
            // distance window drawn over the widths this phase can produce
            lo = ($urandom_range(0, int'(tmo_raw[15:0]) + 2) * sc) >> 8;
            hi = ($urandom_range(0, int'(tmo_raw[15:0]) + 2) * sc) >> 8;
            if (lo > hi) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            if ($urandom_range(0, 5) == 0) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            if (p == 2) begin
                lo = 0;
                hi = 24'hFFFFFF;
            end
            program_regs(tw_raw, tmo_raw, {7'($urandom), 17'(intvl)}, {8'($urandom), 16'(sc)},
                         24'(lo), 24'(hi));
            no_idle   = (p % 4 == 1);
            sent      = 0;
            phase_end = PHASE_TICKS;
            while (sent < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    measure($urandom_range(0, cur_to + 1), $urandom_range(1, cur_to + 2),
                            $urandom_range(0, 3) == 0);
                    sent += cur_tw + cur_to + 3;
                end else if (kind < 9) begin
                    repeat ($urandom_range(1, 8)) begin
                        send_tick($urandom_range(0, 1), $urandom_range(0, 3) == 0);
                        sent++;
                    end
                end else begin
                    // echo never rises
                    measure(cur_to + 2, 0, 1'b1);
                    sent += cur_tw + cur_to + 3;
                end
                repeat ($urandom_range(0, 3)) begin
                    send_tick($urandom_range(0, 1), 1'b0);
                    sent++;
                end
            end
            // quiet tail lets any running measurement finish before the next write
            repeat (cur_tw + cur_to + 3) send_tick(1'b0, 1'b0);
            no_idle = 1'b0;
        end

        drain();
        if (chk_failures == 0 && chk_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
